// ===== design/nm3_pkg.sv =====
// ---------------------------------------------------------------------------
// nm3_pkg
// Shared types and constants for the 3x3 normal matrix block.
// ---------------------------------------------------------------------------
package nm3_pkg;

  // width of the singular threshold register
  localparam int CFG_W = 16;

  typedef logic [CFG_W-1:0] det_min_t;

endpackage

// ===== design/nm3_if.sv =====
// ---------------------------------------------------------------------------
// nm3_if
// Valid/ready channels of the normal matrix block: matrix in, result out,
// and the threshold register write channel.
// ---------------------------------------------------------------------------
interface nm3_in_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                 input ready);
  modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
               output ready);
endinterface

interface nm3_out_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] n00, n01, n02, n10, n11, n12, n20, n21, n22;
  logic                singular;

  modport source(output valid, n00, n01, n02, n10, n11, n12, n20, n21, n22,
                 singular, input ready);
  modport sink(input valid, n00, n01, n02, n10, n11, n12, n20, n21, n22,
               singular, output ready);
endinterface

interface nm3_cfg_if ();
  import nm3_pkg::*;
  logic     valid;
  logic     ready;
  det_min_t data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== design/nm3_cof.sv =====
// ---------------------------------------------------------------------------
// nm3_cof
// One cofactor lane: two signed products, then their exact difference.
// ---------------------------------------------------------------------------
module nm3_cof #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic [1:0]          en,
  input  logic signed [W-1:0] pa,
  input  logic signed [W-1:0] pb,
  input  logic signed [W-1:0] qa,
  input  logic signed [W-1:0] qb,
  output logic signed [2*W:0] cof
);

  logic signed [2*W-1:0] prod_p;
  logic signed [2*W-1:0] prod_q;

  // stage 0: the two diagonal products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_p <= pa * pb;
      prod_q <= qa * qb;
    end
  end

  // stage 1: exact difference, one bit wider
  always_ff @(posedge clk) begin
    if (en[1]) begin
      cof <= (2*W+1)'(prod_p) - (2*W+1)'(prod_q);
    end
  end

endmodule

// ===== design/nm3_det.sv =====
// ---------------------------------------------------------------------------
// nm3_det
// Merge stage: determinant along the first row from the row 0 cofactors,
// its magnitude and sign, and the singular test against the threshold.
// ---------------------------------------------------------------------------
module nm3_det #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic [4:0]            en,
  input  logic signed [W-1:0]   a0 [3],
  input  logic signed [2*W:0]   c0 [3],
  input  nm3_pkg::det_min_t     det_min,
  output logic [3*W:0]          dmag,
  output logic                  dneg,
  output logic                  sing
);
  import nm3_pkg::*;

  localparam int DW  = 3*W + 2;
  localparam int DMW = 3*W + 1;
  localparam logic [DMW:0] RND_D = (DMW+1)'(1) << (2*F-1);

  logic signed [W-1:0]   a_d0 [3];
  logic signed [W-1:0]   a_d1 [3];
  logic signed [2*W:0]   pl [3];
  logic signed [2*W:0]   ph [3];
  logic signed [DW-1:0]  det;
  logic signed [DW-1:0]  det_c;
  logic signed [DW-1:0]  det_neg_c;
  logic [DMW-1:0]        dmag_c;
  logic [DMW:0]          drnd_c;

  // stages 0 and 1: hold the first row beside the cofactor lanes
  always_ff @(posedge clk) begin
    if (en[0]) a_d0 <= a0;
    if (en[1]) a_d1 <= a_d0;
  end

  // stage 2: split each cofactor into a low and a high half and multiply
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        pl[c] <= a_d1[c] * $signed({1'b0, c0[c][W-1:0]});
        ph[c] <= a_d1[c] * $signed(c0[c][2*W:W]);
      end
    end
  end

  // stage 3: sum of the partial products
  always_comb begin
    det_c = '0;
    for (int c = 0; c < 3; c++) begin
      det_c = det_c + (DW'(ph[c]) <<< W) + DW'(pl[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) det <= det_c;
  end

  // stage 4: magnitude, sign and rounded threshold compare
  always_comb begin
    det_neg_c = -det;
    dmag_c    = det[DW-1] ? DMW'(det_neg_c) : DMW'(det);
    drnd_c    = ({1'b0, dmag_c} + RND_D) >> (2*F);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      dmag <= dmag_c;
      dneg <= det[DW-1];
      sing <= drnd_c <= (DMW+1)'(det_min);
    end
  end

endmodule

// ===== design/nm3_lane.sv =====
// ---------------------------------------------------------------------------
// nm3_lane
// One output lane: carries its cofactor to the determinant, then a
// pipelined restoring divider, rounding, selection and saturation.
// ---------------------------------------------------------------------------
module nm3_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic [W+7:0]        en,
  input  logic signed [2*W:0] cof,
  input  logic [3*W:0]        dmag,
  input  logic                dneg,
  input  logic                sing,
  output logic signed [W-1:0] n,
  output logic                sing_o
);

  localparam int XW  = 4*W + 2*F + 3;
  localparam int CW  = 2*W + 1;
  localparam int MW  = 2*W;
  localparam logic [MW-1:0] RND_C = MW'(1) << (F-1);
  localparam logic [MW-1:0] LIM_P = (MW'(1) << (W-1)) - MW'(1);
  localparam logic [MW-1:0] LIM_N = MW'(1) << (W-1);

  logic signed [CW-1:0] c2, c3, c4;
  logic signed [CW-1:0] c4_neg_c;
  logic [MW-1:0]        cmag_c;
  logic [XW-1:0]        num_c;
  logic [XW-1:0]        dd_c;

  logic [XW-1:0] rem_s  [W+1];
  logic [XW-1:0] dd_s   [W+1];
  logic [W:0]    q_s    [W+2];
  logic [MW-1:0] crnd_s [W+2];
  logic          neg_s  [W+2];
  logic          sing_s [W+2];
  logic          big_s  [W+2];

  logic [MW-1:0] mag_c;
  logic [MW-1:0] lim_c;
  logic [MW-1:0] val_c;
  logic          sat_c;

  // stages 2 to 4: cofactor waits for the determinant
  always_ff @(posedge clk) begin
    if (en[2]) c2 <= cof;
    if (en[3]) c3 <= c2;
    if (en[4]) c4 <= c3;
  end

  // stage 5: rounding numerator and doubled divisor
  always_comb begin
    c4_neg_c = -c4;
    cmag_c   = c4[CW-1] ? MW'(c4_neg_c) : MW'(c4);
    num_c    = (XW'(cmag_c) << (2*F+1)) + XW'(dmag);
    dd_c     = XW'(dmag) << 1;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rem_s[0]  <= num_c;
      dd_s[0]   <= dd_c;
      q_s[0]    <= '0;
      big_s[0]  <= num_c >= (dd_c << (W+1));
      crnd_s[0] <= (cmag_c + RND_C) >> F;
      neg_s[0]  <= sing ? c4[CW-1] : (c4[CW-1] ^ dneg);
      sing_s[0] <= sing;
    end
  end

  // stages 6 on: one quotient bit per stage, most significant first
  for (genvar j = 0; j <= W; j++) begin : g_div
    localparam int BIT = W - j;
    logic [XW-1:0] sub;
    logic          take;

    assign sub  = dd_s[j] << BIT;
    assign take = rem_s[j] >= sub;

    always_ff @(posedge clk) begin
      if (en[6+j]) begin
        q_s[j+1]    <= take ? (q_s[j] | ((W+1)'(1) << BIT)) : q_s[j];
        crnd_s[j+1] <= crnd_s[j];
        neg_s[j+1]  <= neg_s[j];
        sing_s[j+1] <= sing_s[j];
        big_s[j+1]  <= big_s[j];
      end
    end

    if (j < W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[6+j]) begin
          rem_s[j+1] <= take ? (rem_s[j] - sub) : rem_s[j];
          dd_s[j+1]  <= dd_s[j];
        end
      end
    end
  end

  // output stage: pick quotient or rounded cofactor, clamp, apply sign
  always_comb begin
    mag_c = sing_s[W+1] ? crnd_s[W+1] : MW'(q_s[W+1]);
    lim_c = neg_s[W+1] ? LIM_N : LIM_P;
    sat_c = (!sing_s[W+1] && big_s[W+1]) || (mag_c > lim_c);
    val_c = sat_c ? lim_c : mag_c;
  end

  always_ff @(posedge clk) begin
    if (en[W+7]) begin
      n      <= neg_s[W+1] ? -$signed(val_c[W-1:0]) : $signed(val_c[W-1:0]);
      sing_o <= sing_s[W+1];
    end
  end

endmodule

// ===== design/normal_matrix_3x3.sv =====
// ---------------------------------------------------------------------------
// normal_matrix_3x3
// Inverse transpose of a 3x3 fixed-point matrix, one matrix per cycle while dout is ready.
// ---------------------------------------------------------------------------
// Usage:
//   din  : nine signed elements a00..a22 of the upper 3x3 of a transform,
//          Q(W-F).F, one matrix per beat.
//   dout : nine elements n00..n22 of the inverse transpose, saturated, and
//          singular; when singular the rounded cofactors come out unscaled.
//   cfg  : det_min, the rounded determinant magnitude at or below which the
//          matrix counts as singular. Always ready; write it while idle.
// The restoring divider in each lane resolves one quotient bit per stage.
// Throughput is one matrix per cycle while the receiver keeps dout ready.
// Every stage holds its own valid bit and moves when the next one is empty
// or moving, so a stalled receiver holds only the final register while
// gaps further up close and din keeps taking beats until all W+8 stages
// are full. Reset clears the valid bits and sets det_min to zero.
// ---------------------------------------------------------------------------
module normal_matrix_3x3 #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  nm3_in_if.sink       din,
  nm3_out_if.source    dout,
  nm3_cfg_if.sink      cfg
);
  import nm3_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int F = FRACTION_BITS;
  localparam int S = W + 8;

  logic [S-1:0]        vld;
  logic [S-1:0]        en;
  det_min_t            det_min;
  logic signed [W-1:0] a [9];
  logic signed [2*W:0] cof [9];
  logic signed [W-1:0] row0 [3];
  logic signed [2*W:0] cof0 [3];
  logic [3*W:0]        dmag;
  logic                dneg;
  logic                sing;
  logic signed [W-1:0] n [9];
  logic [8:0]          sing_l;

  // threshold register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_min <= '0;
    end else if (cfg.valid) begin
      det_min <= cfg.data;
    end
  end

  // stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    en[S-1] = !vld[S-1] || dout.ready;
    for (int k = S-2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= din.valid;
      for (int k = 1; k < S; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign din.ready = en[0];

  assign a[0] = din.a00;
  assign a[1] = din.a01;
  assign a[2] = din.a02;
  assign a[3] = din.a10;
  assign a[4] = din.a11;
  assign a[5] = din.a12;
  assign a[6] = din.a20;
  assign a[7] = din.a21;
  assign a[8] = din.a22;

  // cofactor lanes
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;

      nm3_cof #(.W(W)) u_cof (
        .clk (clk),
        .en  (en[1:0]),
        .pa  (a[R1*3+C1]),
        .pb  (a[R2*3+C2]),
        .qa  (a[R1*3+C2]),
        .qb  (a[R2*3+C1]),
        .cof (cof[r*3+c])
      );

      nm3_lane #(.W(W), .F(F)) u_lane (
        .clk    (clk),
        .en     (en),
        .cof    (cof[r*3+c]),
        .dmag   (dmag),
        .dneg   (dneg),
        .sing   (sing),
        .n      (n[r*3+c]),
        .sing_o (sing_l[r*3+c])
      );
    end
  end

  // determinant merge over the first row
  assign row0 = '{a[0], a[1], a[2]};
  assign cof0 = '{cof[0], cof[1], cof[2]};

  nm3_det #(.W(W), .F(F)) u_det (
    .clk     (clk),
    .en      (en[4:0]),
    .a0      (row0),
    .c0      (cof0),
    .det_min (det_min),
    .dmag    (dmag),
    .dneg    (dneg),
    .sing    (sing)
  );

  // result beat
  assign dout.valid    = vld[S-1];
  assign dout.n00      = n[0];
  assign dout.n01      = n[1];
  assign dout.n02      = n[2];
  assign dout.n10      = n[3];
  assign dout.n11      = n[4];
  assign dout.n12      = n[5];
  assign dout.n20      = n[6];
  assign dout.n21      = n[7];
  assign dout.n22      = n[8];
  assign dout.singular = sing_l[0];

  // any empty stage lets the input take a beat
  a_ready_on_gap: assert property (@(posedge clk) disable iff (rst)
    (vld != '1) |-> din.ready)
    else $error("input stalled with a free pipeline stage");

  // no result appears without something in flight
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (vld == '0) && !din.valid |=> !dout.valid)
    else $error("result beat with empty pipeline");

  // all lanes agree on the singular flag
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (sing_l == '0) || (sing_l == '1))
    else $error("lanes disagree on singular");

endmodule
